// File: sv/rcos_pkg.sv
// Shared types, constants and derived widths of the rotated circular overlay sampler.
// Used by every module of the block and by the port checker.
package rcos_pkg;

  localparam int SOURCE_SIZE  = 256;
  localparam int OVERLAY_SIZE = 256;
  localparam int SCREEN_COLS  = 1024;
  localparam int SCREEN_ROWS  = 768;

  localparam int QFRAC   = 14;
  localparam int ROT_W   = 16;
  localparam int IDX_W   = 16;
  localparam int COL_W   = 32;
  localparam int COORD_W = 8;
  localparam int SCR_W   = 10;

  localparam int MEM_DEPTH = 1 << IDX_W;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int   CFG_IDX_W   = 1;
  localparam logic CFG_ROT_COS = 1'b0;
  localparam logic CFG_ROT_SIN = 1'b1;

  localparam logic signed [ROT_W-1:0] ROT_COS_RST = 16'sd16384;
  localparam logic signed [ROT_W-1:0] ROT_SIN_RST = 16'sd0;

  // centre and radius of the overlay
  localparam int HALF   = OVERLAY_SIZE / 2;
  localparam int DW     = $clog2(HALF + 1) + 1;   // signed offset from centre
  localparam int SQW    = 2 * DW;                 // squared offset
  localparam int PW     = ROT_W + DW;             // rotation partial product
  localparam int RW     = PW + 2;                 // rotated coordinate, Q.14
  localparam longint HALF_Q = longint'(HALF) << QFRAC;
  localparam longint LIM    = longint'(OVERLAY_SIZE) << QFRAC;
  localparam int LW     = $clog2(LIM);            // in-bounds rotated coordinate
  localparam int SSW    = $clog2(SOURCE_SIZE + 1);
  localparam int AW     = LW + SSW;
  localparam int TW     = AW - QFRAC;             // scaled coordinate before divide
  localparam int OVL_L  = $clog2(OVERLAY_SIZE);
  localparam int RK     = TW + OVL_L;             // reciprocal shift
  localparam int MW     = TW + 2;
  localparam longint unsigned RECIP =
    ((longint'(1) << RK) + OVERLAY_SIZE - 1) / OVERLAY_SIZE;
  localparam int SXW    = $clog2(SOURCE_SIZE);
  localparam int IXW    = SXW + SSW + 1;

  localparam int SCR_MOD  = 1 << SCR_W;
  localparam int SCX_BASE = ((SCREEN_COLS - OVERLAY_SIZE) % SCR_MOD + SCR_MOD) % SCR_MOD;
  localparam int SCY_BASE = ((SCREEN_ROWS - OVERLAY_SIZE) % SCR_MOD + SCR_MOD) % SCR_MOD;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   load_index;
    logic [COL_W-1:0]   load_colour;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } rcos_in_t;

  typedef struct packed {
    logic             write_enable;
    logic [COL_W-1:0] colour;
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
  } rcos_out_t;

  // one classified operation for the memory side
  typedef struct packed {
    logic             cmd;
    logic             keep;
    logic [IDX_W-1:0] addr;
    logic [COL_W-1:0] colour;
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
  } rcos_op_t;

endpackage

// File: sv/rcos_front.sv
// Front part: takes items, holds the rotation registers, and turns samples into
// source addresses over four pipeline stages. Depends on rcos_pkg.
module rcos_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcos_pkg::ROT_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rcos_pkg::rcos_in_t              in_data_i,
  output logic                            op_valid_o,
  input  logic                            op_stall_i,
  output rcos_pkg::rcos_op_t              op_data_o
);
  import rcos_pkg::*;

  typedef struct packed {
    logic             cmd;
    logic             keep;
    logic [IDX_W-1:0] index;
    logic [COL_W-1:0] colour;
    logic [SCR_W-1:0] scr_x;
    logic [SCR_W-1:0] scr_y;
  } meta_t;

  logic signed [ROT_W-1:0] rot_cos_q, rot_sin_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  meta_t m1_d, m1_q, m2_d, m2_q, m3_q, m4_q;

  logic signed [11:0]   dx_full, dy_full;
  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] pcx_d, psy_d, psx_d, pcy_d;
  logic signed [PW-1:0] pcx_q, psy_q, psx_q, pcy_q;
  logic signed [SQW-1:0] dx2_d, dy2_d, dx2_q, dy2_q;

  logic signed [RW-1:0] rx, ry;
  logic signed [SQW:0]  dist2;
  logic                 in_circle, x_ok, y_ok;
  logic [LW-1:0]        rxu_q, ryu_q;

  logic [AW-1:0]        ax, ay;
  logic [TW-1:0]        tx_q, ty_q;

  logic [TW+MW-1:0]     px, py;
  logic [SXW-1:0]       sx_q, sy_q;
  logic [IXW-1:0]       idx_full;

  // rotation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cos_q <= ROT_COS_RST;
      rot_sin_q <= ROT_SIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROT_COS: rot_cos_q <= cfg_data_i;
        CFG_ROT_SIN: rot_sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rdy4       = !v4_q || !op_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // stage 1: centre the pixel and form the products
  assign dx_full = $signed({4'b0, in_data_i.out_x}) - 12'(HALF);
  assign dy_full = $signed({4'b0, in_data_i.out_y}) - 12'(HALF);
  assign dx      = dx_full[DW-1:0];
  assign dy      = dy_full[DW-1:0];
  assign pcx_d   = PW'(rot_cos_q) * PW'(dx);
  assign psy_d   = PW'(rot_sin_q) * PW'(dy);
  assign psx_d   = PW'(rot_sin_q) * PW'(dx);
  assign pcy_d   = PW'(rot_cos_q) * PW'(dy);
  assign dx2_d   = SQW'(dx) * SQW'(dx);
  assign dy2_d   = SQW'(dy) * SQW'(dy);

  always_comb begin
    m1_d        = '0;
    m1_d.cmd    = in_data_i.cmd;
    m1_d.keep   = (11'(in_data_i.out_x) < 11'(OVERLAY_SIZE)) &&
                  (11'(in_data_i.out_y) < 11'(OVERLAY_SIZE));
    m1_d.index  = in_data_i.load_index;
    m1_d.colour = in_data_i.load_colour;
    m1_d.scr_x  = SCR_W'(SCX_BASE) + SCR_W'(in_data_i.out_x);
    m1_d.scr_y  = SCR_W'(SCY_BASE) + SCR_W'(in_data_i.out_y);
  end

  // stage 2: rotate, circle and bounds tests
  assign rx        = RW'(pcx_q) - RW'(psy_q) + RW'(HALF_Q);
  assign ry        = RW'(psx_q) + RW'(pcy_q) + RW'(HALF_Q);
  assign dist2     = (SQW+1)'(dx2_q) + (SQW+1)'(dy2_q);
  assign in_circle = dist2 <= (SQW+1)'(HALF * HALF);
  assign x_ok      = !rx[RW-1] && (rx < RW'(LIM));
  assign y_ok      = !ry[RW-1] && (ry < RW'(LIM));

  always_comb begin
    m2_d      = m1_q;
    m2_d.keep = m1_q.keep && in_circle && x_ok && y_ok;
  end

  // stage 3: scale to source units, drop the fraction
  assign ax = AW'(rxu_q) * AW'(SOURCE_SIZE);
  assign ay = AW'(ryu_q) * AW'(SOURCE_SIZE);

  // stage 4: divide by overlay size through an exact reciprocal
  assign px = (TW+MW)'(tx_q) * (TW+MW)'(RECIP);
  assign py = (TW+MW)'(ty_q) * (TW+MW)'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      m1_q  <= m1_d;
      pcx_q <= pcx_d;
      psy_q <= psy_d;
      psx_q <= psx_d;
      pcy_q <= pcy_d;
      dx2_q <= dx2_d;
      dy2_q <= dy2_d;
    end
    if (rdy2 && v1_q) begin
      m2_q  <= m2_d;
      rxu_q <= rx[LW-1:0];
      ryu_q <= ry[LW-1:0];
    end
    if (rdy3 && v2_q) begin
      m3_q <= m2_q;
      tx_q <= ax[AW-1:QFRAC];
      ty_q <= ay[AW-1:QFRAC];
    end
    if (rdy4 && v3_q) begin
      m4_q <= m3_q;
      sx_q <= px[RK +: SXW];
      sy_q <= py[RK +: SXW];
    end
  end

  // read index wraps to the store width
  assign idx_full = IXW'(sx_q) + IXW'(sy_q) * IXW'(SOURCE_SIZE);

  always_comb begin
    op_data_o          = '0;
    op_data_o.cmd      = m4_q.cmd;
    op_data_o.keep     = m4_q.keep;
    op_data_o.screen_x = m4_q.scr_x;
    op_data_o.screen_y = m4_q.scr_y;
    if (m4_q.cmd == CMD_LOAD) begin
      op_data_o.addr   = m4_q.index;
      op_data_o.colour = m4_q.colour;
    end else begin
      op_data_o.addr   = IDX_W'(idx_full);
    end
  end

  assign op_valid_o = v4_q;

endmodule

// File: sv/rcos_fifo.sv
// Short queue of classified operations between front and back parts.
// Depends on rcos_pkg.
module rcos_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  rcos_pkg::rcos_op_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_stall_i,
  output rcos_pkg::rcos_op_t pop_data_o
);
  import rcos_pkg::*;

  rcos_op_t       ent_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q;
  logic           push, pop;

  assign push_stall_o = (cnt_q == (QAW+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_data_o   = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: sv/rcos_back.sv
// Back part: source picture memory, the load writes and sample reads, and the
// output register. Depends on rcos_pkg.
module rcos_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  output logic                op_stall_o,
  input  rcos_pkg::rcos_op_t  op_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcos_pkg::rcos_out_t out_data_o
);
  import rcos_pkg::*;

  logic [COL_W-1:0] mem_q [MEM_DEPTH];
  logic [COL_W-1:0] rdata_q;

  logic             b1_v_q, b1_we_q;
  logic [SCR_W-1:0] b1_sx_q, b1_sy_q;
  logic             out_v_q;
  rcos_out_t        out_q;

  logic out_rdy, b1_rdy, is_load, fire;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign b1_rdy     = !b1_v_q || out_rdy;
  assign is_load    = (op_data_i.cmd == CMD_LOAD);
  // loads never wait on the output side
  assign op_stall_o = is_load ? 1'b0 : !b1_rdy;
  assign fire       = op_valid_i && !op_stall_o;

  always_ff @(posedge clk_i) begin
    if (fire && is_load) mem_q[op_data_i.addr] <= op_data_i.colour;
  end

  // read data holds while the beat waits in b1
  always_ff @(posedge clk_i) begin
    if (fire && !is_load) begin
      rdata_q <= mem_q[op_data_i.addr];
      b1_we_q <= op_data_i.keep;
      b1_sx_q <= op_data_i.screen_x;
      b1_sy_q <= op_data_i.screen_y;
    end
    if (out_rdy && b1_v_q) begin
      out_q.write_enable <= b1_we_q;
      out_q.colour       <= b1_we_q ? rdata_q : '0;
      out_q.screen_x     <= b1_sx_q;
      out_q.screen_y     <= b1_sy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (b1_rdy)  b1_v_q  <= fire && !is_load;
      if (out_rdy) out_v_q <= b1_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/rotated_circular_overlay_sampler_core.sv
// Rotated circular overlay sampler: takes one item per clock, load or sample, at a
// sustained rate of one per cycle while no stall holds the pipeline. A sample passes
// seven registers: four arithmetic stages (centre and multiply, rotate and test,
// scale, reciprocal divide), a four-entry queue, the registered read of the 64K x 32
// source memory and the output register. Loads write the memory in queue order, so a
// sample always sees every load accepted before it; they give no result. The memory
// has no reset and no clearing pass: sampling a pixel that was never loaded returns an
// arbitrary colour. The user must write the rotation registers only while the block
// is idle; the block itself does not enforce this.
// Depends on rcos_pkg, rcos_front, rcos_fifo and rcos_back.
module rotated_circular_overlay_sampler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcos_pkg::ROT_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rcos_pkg::rcos_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rcos_pkg::rcos_out_t            out_data_o
);
  import rcos_pkg::*;

  logic     fr_valid, fr_stall, bk_valid, bk_stall;
  rcos_op_t fr_op, bk_op;

  rcos_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .op_valid_o (fr_valid),
    .op_stall_i (fr_stall),
    .op_data_o  (fr_op)
  );

  rcos_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_stall_o (fr_stall),
    .push_data_i  (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_stall_i  (bk_stall),
    .pop_data_o   (bk_op)
  );

  rcos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (bk_valid),
    .op_stall_o  (bk_stall),
    .op_data_i   (bk_op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/rcos_checker.sv
// Port-level checks of the sampler's result channel, bound to the top level.
// Depends on rcos_pkg and rotated_circular_overlay_sampler_core.
module rcos_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input rcos_pkg::rcos_out_t out_data_i
);
  import rcos_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_data_i))
    else $error("stalled result beat changed");

  // a rejected pixel never carries a colour
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.write_enable |-> out_data_i.colour == '0)
    else $error("rejected pixel with nonzero colour");

  // nothing can come out in the first cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result beat right after reset");

endmodule

bind rotated_circular_overlay_sampler_core rcos_checker u_rcos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
